### rtl/srq_pkg.sv
// ----------------------------------------------------------------------------
// srq_pkg
// Shared types and codes for the shifting record queue: operation and
// status codes, the record payload and the control word sent to every cell.
// ----------------------------------------------------------------------------
package srq_pkg;

  // Operation codes carried on the input transfer
  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_DELETE  = 2'd2,
    OP_MEMBER  = 2'd3
  } srq_op_t;

  // Status codes carried on the result transfer
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } srq_status_t;

  localparam int unsigned FIELD_W = 16;

  // Non-key part of a record
  typedef struct packed {
    logic [FIELD_W-1:0] duration;
    logic [FIELD_W-1:0] price;
    logic [FIELD_W-1:0] hold_time;
  } srq_fields_t;

  // Broadcast control for one cycle of the cell row
  typedef struct packed {
    logic load;   // enqueue goes ahead this cycle
    logic shift;  // a removal goes ahead this cycle
  } srq_ctrl_t;

endpackage

### rtl/srq_cell.sv
// ----------------------------------------------------------------------------
// srq_cell
// One slot of the queue. Holds a record, loads a new one when it is the
// tail slot of an enqueue, takes its upper neighbour's record when a
// removal closes the gap over it, and compares its key for a search.
// ----------------------------------------------------------------------------
module srq_cell
  import srq_pkg::*;
#(
  parameter int unsigned IDX       = 0,
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned CMP_W     = 5
) (
  input  logic                 clk,
  input  srq_ctrl_t            ctrl,
  input  logic [CMP_W-1:0]     count,
  input  logic [CMP_W-1:0]     rm_idx,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  srq_fields_t          in_fields,
  input  logic [KEY_WIDTH-1:0] nbr_key,
  input  srq_fields_t          nbr_fields,
  output logic [KEY_WIDTH-1:0] key,
  output srq_fields_t          fields,
  output logic                 match,
  output logic                 hit
);

  localparam logic [CMP_W-1:0] MY_IDX   = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] NEXT_IDX = CMP_W'(IDX + 1);

  logic occupied;
  logic is_tail;
  logic take_nbr;

  // Decide this slot's role from its place against count and removal point
  assign occupied = (MY_IDX < count);
  assign is_tail  = (MY_IDX == count);
  assign take_nbr = (MY_IDX >= rm_idx) && (NEXT_IDX < count);
  assign hit      = (MY_IDX == rm_idx);
  assign match    = occupied && (key == in_key);

  // Load at the tail, advance from the neighbour on removal, else hold
  always_ff @(posedge clk) begin
    if (ctrl.load && is_tail) begin
      key    <= in_key;
      fields <= in_fields;
    end else if (ctrl.shift && take_nbr) begin
      key    <= nbr_key;
      fields <= nbr_fields;
    end
  end

endmodule

### rtl/shifting_record_queue_top.sv
// ----------------------------------------------------------------------------
// shifting_record_queue_top
// Bounded record queue built as a row of shifting cells, with enqueue,
// dequeue, delete-at-position and key search.
// ----------------------------------------------------------------------------
// One operation is taken per clock cycle and its result appears in the
// output register on the following cycle. Every cell updates and compares
// in the same cycle, so the rate is set by the cell update and
// by the output register: a new item is accepted whenever the output
// register is empty or its result is being taken in that cycle. Entries are
// kept packed from slot 0; removals shift all later slots forward at once.
module shifting_record_queue_top
  import srq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] key,
  input  logic [15:0] duration,
  input  logic [15:0] price,
  input  logic [15:0] hold_time,
  input  logic [3:0]  position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_key,
  output logic [15:0] out_duration,
  output logic [15:0] out_price,
  output logic [15:0] out_hold_time,
  output logic        found,
  output logic [1:0]  status,
  output logic [4:0]  occupancy
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CW > 4) ? CW : 4;

  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [CMP_W-1:0]     count_ext;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     rm_idx;
  logic                 accept;
  srq_op_t              op;
  srq_status_t          st;
  srq_ctrl_t            ctrl;
  logic [63:0]          key_wide;
  logic [KEY_WIDTH-1:0] in_key;
  srq_fields_t          in_fields;

  logic [KEY_WIDTH-1:0] cell_key    [DEPTH];
  srq_fields_t          cell_fields [DEPTH];
  logic [KEY_WIDTH-1:0] nbr_key     [DEPTH];
  srq_fields_t          nbr_fields  [DEPTH];
  logic [DEPTH-1:0]     cell_match;
  logic [DEPTH-1:0]     cell_hit;

  logic [KEY_WIDTH-1:0] rm_key;
  srq_fields_t          rm_fields;
  logic [63:0]          rm_key_wide;
  logic [15:0]          occ_wide;
  logic                 removing;

  // Accept while the output register is free or being drained
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign op        = srq_op_t'(operation);
  assign key_wide  = {32'd0, key};
  assign in_key    = key_wide[KEY_WIDTH-1:0];
  assign in_fields = '{duration: duration, price: price, hold_time: hold_time};

  assign count_ext = CMP_W'(count);
  assign pos_ext   = CMP_W'(position);
  assign rm_idx    = (op == OP_DEQUEUE) ? '0 : pos_ext;

  // Decode the operation into status, cell control and the next count
  always_comb begin
    st         = ST_OK;
    ctrl       = '0;
    count_next = count;
    unique case (op)
      OP_ENQUEUE: begin
        if (count_ext == CMP_W'(DEPTH)) begin
          st = ST_FULL;
        end else begin
          ctrl.load  = accept;
          count_next = count + CW'(1);
        end
      end
      OP_DEQUEUE: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else begin
          ctrl.shift = accept;
          count_next = count - CW'(1);
        end
      end
      OP_DELETE: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else if (pos_ext >= count_ext) begin
          st = ST_RANGE;
        end else begin
          ctrl.shift = accept;
          count_next = count - CW'(1);
        end
      end
      OP_MEMBER: begin
        st = ST_OK;
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  assign removing = (op == OP_DEQUEUE || op == OP_DELETE) && (st == ST_OK);

  // Build the cell row, each slot but the last fed by its upper neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      assign nbr_key[i]    = cell_key[i];
      assign nbr_fields[i] = cell_fields[i];
    end else begin : g_inner
      assign nbr_key[i]    = cell_key[i+1];
      assign nbr_fields[i] = cell_fields[i+1];
    end

    srq_cell #(
      .IDX       (i),
      .KEY_WIDTH (KEY_WIDTH),
      .CMP_W     (CMP_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_ext),
      .rm_idx     (rm_idx),
      .in_key     (in_key),
      .in_fields  (in_fields),
      .nbr_key    (nbr_key[i]),
      .nbr_fields (nbr_fields[i]),
      .key        (cell_key[i]),
      .fields     (cell_fields[i]),
      .match      (cell_match[i]),
      .hit        (cell_hit[i])
    );
  end

  // Pick out the removed record from the one slot that is hit
  always_comb begin
    rm_key    = '0;
    rm_fields = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_hit[i]) begin
        rm_key    = rm_key | cell_key[i];
        rm_fields = rm_fields | cell_fields[i];
      end
    end
  end

  assign rm_key_wide = 64'(rm_key);
  assign occ_wide    = 16'(count_next);

  // Hold the count; it moves only on an accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Result register: fill on accept, drop once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_key       <= removing ? rm_key_wide[31:0] : 32'd0;
      out_duration  <= removing ? rm_fields.duration : 16'd0;
      out_price     <= removing ? rm_fields.price : 16'd0;
      out_hold_time <= removing ? rm_fields.hold_time : 16'd0;
      found         <= (op == OP_MEMBER) && (|cell_match);
      status        <= st;
      occupancy     <= occ_wide[4:0];
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for shifting_record_queue_top. A directed opening
// covers the empty and full queue, field extremes and both ends of the
// position range. Random traffic follows in randomly chosen filling, draining
// and balanced phases, keys drawn often from a small pool so that searches
// hit. A local copy of the queue predicts every result, and each transfer
// on the result channel is checked field by field against it, in order.
// ----------------------------------------------------------------------------
module tb_top
  import srq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int          RANDOM_CMDS  = 1200;
  localparam int          IDLE_PERCENT = 12;
  localparam int          LONG_HOLD    = 80;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          TAIL_CYCLES  = 8;

  typedef struct packed {
    srq_op_t     op;
    logic [31:0] key;
    logic [15:0] duration;
    logic [15:0] price;
    logic [15:0] hold_time;
    logic [3:0]  position;
    bit          drain_first;  // hold this command until all results are in
  } queue_cmd_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] duration;
    logic [15:0] price;
    logic [15:0] hold_time;
    logic        found;
    srq_status_t status;
    logic [4:0]  occupancy;
  } queue_result_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} stim_mix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [31:0] key = '0;
  logic [15:0] duration = '0;
  logic [15:0] price = '0;
  logic [15:0] hold_time = '0;
  logic [3:0]  position = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_key;
  logic [15:0] out_duration;
  logic [15:0] out_price;
  logic [15:0] out_hold_time;
  logic        found;
  logic [1:0]  status;
  logic [4:0]  occupancy;

  queue_cmd_t    cmd_backlog[$];
  queue_result_t awaited_results[$];
  queue_cmd_t    live_cmd;
  bit            all_sent = 1'b0;
  int            n_accepted = 0;
  int            n_checked = 0;
  int            n_errors = 0;
  int            idle_cycles = 0;
  int            hold_left = 0;
  bit            long_hold_done = 1'b0;

  // Shadow copy of the queue contents
  logic [31:0]   shadow_key      [QUEUE_DEPTH];
  logic [15:0]   shadow_duration [QUEUE_DEPTH];
  logic [15:0]   shadow_price    [QUEUE_DEPTH];
  logic [15:0]   shadow_hold     [QUEUE_DEPTH];
  int unsigned   shadow_count = 0;

  shifting_record_queue_top #(
    .DEPTH     (QUEUE_DEPTH),
    .KEY_WIDTH (32)
  ) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one command to the shadow queue and return the result it yields
  function automatic queue_result_t predict_queue_result(queue_cmd_t c);
    queue_result_t r;
    int unsigned   slot;
    r = '0;
    r.status = ST_OK;
    case (c.op)
      OP_ENQUEUE: begin
        if (shadow_count == QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_key[shadow_count]      = c.key;
          shadow_duration[shadow_count] = c.duration;
          shadow_price[shadow_count]    = c.price;
          shadow_hold[shadow_count]     = c.hold_time;
          shadow_count++;
        end
      end
      OP_DEQUEUE, OP_DELETE: begin
        slot = (c.op == OP_DELETE) ? c.position : 0;
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (slot >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          r.key       = shadow_key[slot];
          r.duration  = shadow_duration[slot];
          r.price     = shadow_price[slot];
          r.hold_time = shadow_hold[slot];
          // close the gap behind the removed record
          for (int unsigned j = slot; j + 1 < shadow_count; j++) begin
            shadow_key[j]      = shadow_key[j + 1];
            shadow_duration[j] = shadow_duration[j + 1];
            shadow_price[j]    = shadow_price[j + 1];
            shadow_hold[j]     = shadow_hold[j + 1];
          end
          shadow_count--;
        end
      end
      default: begin
        for (int unsigned j = 0; j < shadow_count; j++) begin
          if (shadow_key[j] == c.key) r.found = 1'b1;
        end
      end
    endcase
    r.occupancy = shadow_count[4:0];
    return r;
  endfunction

  function automatic void queue_cmd(srq_op_t op, logic [31:0] k, logic [15:0] d,
                                    logic [15:0] p, logic [15:0] h, logic [3:0] pos,
                                    bit drain);
    queue_cmd_t c;
    c.op          = op;
    c.key         = k;
    c.duration    = d;
    c.price       = p;
    c.hold_time   = h;
    c.position    = pos;
    c.drain_first = drain;
    cmd_backlog.push_back(c);
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      n_errors++;
    end
  endtask

  // Build the command list, release reset, then wait for all results and report
  initial begin : build_stimulus
    logic [31:0] key_pool[8];
    logic [31:0] k;
    stim_mix_t   mix;
    int          mix_left;
    int          roll;
    srq_op_t     op;
    mix = MIX_FILL;
    mix_left = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom();

    // empty queue: search, dequeue and delete
    queue_cmd(OP_MEMBER, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0);
    queue_cmd(OP_DEQUEUE, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0);
    queue_cmd(OP_DELETE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 1'b0);
    // fill to the brim with extreme and walking-bit records
    queue_cmd(OP_ENQUEUE, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0);
    queue_cmd(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 1'b0);
    for (int i = 2; i < QUEUE_DEPTH; i++) begin
      queue_cmd(OP_ENQUEUE, (i % 2) ? ~(32'h1 << (2 * i)) : (32'h1 << (2 * i)),
                16'h1 << i, ~(16'h1 << i), 16'(i * 16'h1111), 4'(i), 1'b0);
    end
    // full queue, search hit and miss, delete at both ends of the range
    queue_cmd(OP_ENQUEUE, 32'h1234_5678, 16'hAAAA, 16'h5555, 16'hA5A5, 4'd0, 1'b0);
    queue_cmd(OP_MEMBER, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0);
    queue_cmd(OP_MEMBER, 32'h1234_5678, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0);
    queue_cmd(OP_DELETE, 32'h0, 16'h0, 16'h0, 16'h0, 4'd15, 1'b0);
    queue_cmd(OP_DELETE, 32'h0, 16'h0, 16'h0, 16'h0, 4'd15, 1'b0);
    queue_cmd(OP_DEQUEUE, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b0);
    queue_cmd(OP_DELETE, 32'h0, 16'h0, 16'h0, 16'h0, 4'd0, 1'b1);

    // random phases of filling, draining and balanced traffic
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (mix_left == 0) begin
        mix = stim_mix_t'($urandom_range(2));
        mix_left = $urandom_range(60, 20);
      end
      mix_left--;
      roll = $urandom_range(99);
      case (mix)
        MIX_FILL:  op = (roll < 70) ? OP_ENQUEUE : (roll < 80) ? OP_DEQUEUE :
                        (roll < 88) ? OP_DELETE : OP_MEMBER;
        MIX_DRAIN: op = (roll < 15) ? OP_ENQUEUE : (roll < 55) ? OP_DEQUEUE :
                        (roll < 85) ? OP_DELETE : OP_MEMBER;
        default:   op = (roll < 30) ? OP_ENQUEUE : (roll < 55) ? OP_DEQUEUE :
                        (roll < 75) ? OP_DELETE : OP_MEMBER;
      endcase
      k = $urandom_range(1) ? key_pool[$urandom_range(7)] : 32'($urandom());
      queue_cmd(op, k, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                $urandom_range(1) ? 4'($urandom_range(7)) : 4'($urandom_range(15)),
                (n % 150) == 149);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (all_sent);
    wait (n_checked == n_accepted);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0 && awaited_results.size() == 0) begin
      $display("shifting_record_queue_top regression: pass");
    end else begin
      $display("shifting_record_queue_top regression: fail");
    end
    $finish;
  end

  // Command driver: predict on each transfer, then offer the next command
  always @(posedge clk) begin : drive_cmds
    bit         taken;
    bit         res_taken;
    bit         quiet;
    queue_cmd_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      taken     = in_valid && !in_stall;
      res_taken = out_valid && !out_stall;
      quiet     = n_accepted >= 500 && n_accepted < 750;
      if (taken) begin
        awaited_results.push_back(predict_queue_result(live_cmd));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || taken) begin
        if (cmd_backlog.size() == 0) begin
          in_valid <= 1'b0;
          all_sent <= 1'b1;
        end else if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
          in_valid <= 1'b0;
        end else if (cmd_backlog[0].drain_first &&
                     n_accepted + taken != n_checked + res_taken) begin
          // pause until every outstanding result has been taken
          in_valid <= 1'b0;
        end else begin
          nxt = cmd_backlog.pop_front();
          live_cmd  <= nxt;
          in_valid  <= 1'b1;
          operation <= nxt.op;
          key       <= nxt.key;
          duration  <= nxt.duration;
          price     <= nxt.price;
          hold_time <= nxt.hold_time;
          position  <= nxt.position;
        end
      end
    end
  end

  // Result monitor: check each transfer and drive the receiver's stall
  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked <= n_checked + 1;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual key %0h status %0d",
                   $realtime, out_key, status);
          n_errors++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("out_key", want.key, out_key);
          compare_field("out_duration", want.duration, out_duration);
          compare_field("out_price", want.price, out_price);
          compare_field("out_hold_time", want.hold_time, out_hold_time);
          compare_field("found", want.found, found);
          compare_field("status", want.status, status);
          compare_field("occupancy", want.occupancy, occupancy);
        end
      end
      // one long hold-off lets the block back up onto its input
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (n_checked == 300 && !long_hold_done) begin
        out_stall      <= 1'b1;
        hold_left      <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else if (n_checked >= 500 && n_checked < 750) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Watchdog: give up when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("shifting_record_queue_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
